@@ hdl/tppf_pkg.sv @@
// tppf_pkg: shared types, codes and address helpers for the tile pattern pixel fetch
// depends on nothing; imported by tppf_vram, tile_pattern_pixel_fetch, tppf_checker and the testbench
`default_nettype none

package tppf_pkg;

	localparam int VRAM_ADDR_BITS = 17;
	localparam int VRAM_DEPTH     = 1 << VRAM_ADDR_BITS;
	localparam int REG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 17;

	// screen mode codes
	localparam logic [4:0] SCREEN_G1 = 5'b00000;
	localparam logic [4:0] SCREEN_G2 = 5'b00100;
	localparam logic [4:0] SCREEN_G3 = 5'b01000;
	localparam logic [4:0] SCREEN_G4 = 5'b01100;

	// item kinds
	localparam logic ITEM_WRITE = 1'b0;
	localparam logic ITEM_PIXEL = 1'b1;

	// register indexes
	localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_MODE = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_NAME_BASE   = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_PAT_BASE    = 2'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_COLOR_BASE  = 2'd3;

	// bitmap mode keeps the two top bits of the name table base
	localparam logic [16:0] BITMAP_PAGE_MASK = 17'h18000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAT,
		ST_COL
	} seq_state_t;

	typedef enum logic [1:0] {
		KIND_TILE1,
		KIND_TILE2,
		KIND_BITMAP,
		KIND_NONE
	} pix_kind_t;

	typedef struct packed {
		logic                      en;
		logic                      we;
		logic [VRAM_ADDR_BITS-1:0] addr;
		logic [7:0]                wdata;
	} vram_req_t;

	function automatic pix_kind_t decode_kind(input logic [4:0] screen_mode);
		pix_kind_t k;
		case (screen_mode)
			SCREEN_G1: k = KIND_TILE1;
			SCREEN_G2: k = KIND_TILE2;
			SCREEN_G3: k = KIND_TILE2;
			SCREEN_G4: k = KIND_BITMAP;
			default:   k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [16:0] name_addr(input logic [16:0] ntb, input logic [7:0] x,
			input logic [7:0] y);
		return {3'b000, ntb[13:10], y[7:3], x[7:3]};
	endfunction

	// y*128 + x/2 stays below 2^15, so the page bits just concatenate
	function automatic logic [16:0] bitmap_addr(input logic [16:0] ntb, input logic [7:0] x,
			input logic [7:0] y);
		logic [16:0] page;
		page = ntb & BITMAP_PAGE_MASK;
		return {page[16:15], y, x[7:1]};
	endfunction

	// row band bits of graphic2/3: {bit12, bit11}
	function automatic logic [1:0] band_bits(input logic [16:0] ptb, input logic [7:0] y);
		return {ptb[12] & (y[7:6] == 2'b10), ptb[11] & (y[7:6] == 2'b01)};
	endfunction

	function automatic logic [16:0] pat_addr(input pix_kind_t k, input logic [16:0] ptb,
			input logic [7:0] name, input logic [7:0] y);
		logic [16:0] a;
		if (k == KIND_TILE1)
			a = {3'b000, ptb[13:11], name, y[2:0]};
		else
			a = {3'b000, ptb[13], band_bits(ptb, y), name, y[2:0]};
		return a;
	endfunction

	function automatic logic [16:0] col_addr(input pix_kind_t k, input logic [16:0] ptb,
			input logic [16:0] ctb, input logic [7:0] name, input logic [7:0] y);
		logic [16:0] a;
		if (k == KIND_TILE1)
			a = {3'b000, ctb[13:6], 1'b0, name[7:3]};
		else
			a = {3'b000, ctb[13], band_bits(ptb, y), name, y[2:0]};
		return a;
	endfunction

endpackage

`default_nettype wire

@@ hdl/tppf_vram.sv @@
// tppf_vram: single-port byte-wide video memory, registered read
// depends on tppf_pkg
`default_nettype none

module tppf_vram
	import tppf_pkg::*;
(
	input  wire logic      clk,
	input  wire vram_req_t req,
	output logic [7:0]     rd_data
);

	logic [7:0] mem [VRAM_DEPTH];

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end
			rd_data <= mem[req.addr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/tile_pattern_pixel_fetch.sv @@
// tile_pattern_pixel_fetch: tile/bitmap pixel colour lookup over a 128 KiB video memory
// depends on tppf_pkg and tppf_vram
// a tile pixel (graphic1/2/3) reads name, pattern and colour bytes in turn, a bitmap
//   pixel one byte, other modes none, then it strobes; a write beat returns nothing
// throughput: a tile pixel holds busy until its three dependent reads on the single vram
//   port are issued; bitmap pixels and writes one per cycle; results cannot be stalled
// reset: control and config registers clear; vram content is undefined until written
`default_nettype none

module tile_pattern_pixel_fetch
	import tppf_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// command channel
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     mode,
	input  wire logic [7:0]               pixel_x,
	input  wire logic [7:0]               pixel_y,
	input  wire logic [16:0]              write_address,
	input  wire logic [7:0]               write_data,
	// result channel
	output logic                          result_valid,
	output logic [3:0]                    pixel_color,
	// configuration writes
	input  wire logic                     cfg_we,
	input  wire logic [REG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	// config registers
	logic [4:0]  screen_mode_q;
	logic [16:0] name_base_q;
	logic [16:0] pat_base_q;
	logic [16:0] color_base_q;

	// sequencer and per-pixel context
	seq_state_t  state_q, state_d;
	pix_kind_t   kind_q;
	pix_kind_t   kind_new;
	logic [7:0]  x_q;
	logic [7:0]  y_q;
	logic [7:0]  name_q;
	logic [7:0]  pat_q;
	logic        fin_q, fin_d;
	logic        accept;
	logic [3:0]  color_d;

	vram_req_t   req;
	logic [7:0]  rd_data;

	tppf_vram u_vram (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_mode_q <= '0;
			name_base_q   <= '0;
			pat_base_q    <= '0;
			color_base_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_MODE: screen_mode_q <= cfg_data[4:0];
				REG_NAME_BASE:   name_base_q   <= cfg_data;
				REG_PAT_BASE:    pat_base_q    <= cfg_data;
				REG_COLOR_BASE:  color_base_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// the port is free whenever the sequencer is idle; a new beat issues its
	// first vram access on the accepting edge
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign kind_new = decode_kind(screen_mode_q);

	always_comb begin
		state_d   = state_q;
		fin_d     = 1'b0;
		req.en    = 1'b0;
		req.we    = 1'b0;
		req.addr  = write_address[VRAM_ADDR_BITS-1:0];
		req.wdata = write_data;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req.en = 1'b1;
					if (mode == ITEM_WRITE) begin
						req.we = 1'b1;
					end else begin
						case (kind_new)
							KIND_TILE1, KIND_TILE2: begin
								// name byte read, then walk pattern and colour
								req.addr = VRAM_ADDR_BITS'(name_addr(name_base_q, pixel_x,
									pixel_y));
								state_d  = ST_PAT;
							end
							KIND_BITMAP: begin
								req.addr = VRAM_ADDR_BITS'(bitmap_addr(name_base_q, pixel_x,
									pixel_y));
								fin_d    = 1'b1;
							end
							default: begin
								// unimplemented mode, colour is zero, no read needed
								req.en = 1'b0;
								fin_d  = 1'b1;
							end
						endcase
					end
				end
			end
			ST_PAT: begin
				// name byte is on rd_data now
				req.en   = 1'b1;
				req.addr = VRAM_ADDR_BITS'(pat_addr(kind_q, pat_base_q, rd_data, y_q));
				state_d  = ST_COL;
			end
			ST_COL: begin
				// pattern byte is on rd_data now
				req.en   = 1'b1;
				req.addr = VRAM_ADDR_BITS'(col_addr(kind_q, pat_base_q, color_base_q, name_q,
					y_q));
				fin_d    = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fin_q        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			fin_q        <= fin_d;
			result_valid <= fin_q;
		end
	end

	// pixel context; a new beat may overwrite it in the same cycle the
	// previous pixel finishes, its data has been used by then
	always_ff @(posedge clk) begin
		if (accept && mode == ITEM_PIXEL) begin
			x_q    <= pixel_x;
			y_q    <= pixel_y;
			kind_q <= kind_new;
		end
		if (state_q == ST_PAT) begin
			name_q <= rd_data;
		end
		if (state_q == ST_COL) begin
			pat_q <= rd_data;
		end
	end

	// finishing cycle: rd_data carries the colour byte (tile) or pixel pair (bitmap)
	always_comb begin
		case (kind_q)
			KIND_TILE1, KIND_TILE2: color_d = pat_q[~x_q[2:0]] ? rd_data[7:4] : rd_data[3:0];
			KIND_BITMAP:            color_d = x_q[0] ? rd_data[3:0] : rd_data[7:4];
			default:                color_d = 4'h0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fin_q) begin
			pixel_color <= color_d;
		end
	end

	// sequencer always walks name, pattern, colour without stopping
	a_pat_then_col: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAT |=> state_q == ST_COL)
		else $error("pattern fetch not followed by colour fetch");

	// a finishing pixel always produces its strobe in the following cycle
	a_fin_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> result_valid)
		else $error("finished pixel lost its result strobe");

	// a write beat never yields a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == ITEM_WRITE |=> !fin_q)
		else $error("write beat produced a pixel");

	// the vram port is never written while a pixel walk owns it
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !req.we)
		else $error("vram write during pixel fetch");

endmodule

`default_nettype wire

@@ dv/tppf_checker.sv @@
// tppf_checker: watches the command, result and register channels and checks each pixel colour
// keeps its own copy of video memory and registers; depends on tppf_pkg for codes and widths
module tppf_checker
	import tppf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic                     mode,
	input  logic [7:0]               pixel_x,
	input  logic [7:0]               pixel_y,
	input  logic [16:0]              write_address,
	input  logic [7:0]               write_data,
	input  logic                     result_valid,
	input  logic [3:0]               pixel_color,
	input  logic                     cfg_we,
	input  logic [REG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output int                       fail_count,
	output int                       colors_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]  vram_copy [VRAM_DEPTH];
	logic [4:0]  screen_mode;
	logic [16:0] name_base;
	logic [16:0] pattern_base;
	logic [16:0] color_base;
	logic [3:0]  expected_colors [$];
	int          errors = 0;

	assign fail_count = errors;

	task automatic report_mismatch(input string msg);
		$display("%0t ns  pixel check: %s", $time, msg);
		errors++;
	endtask

	function automatic logic [3:0] predict_color(input logic [7:0] x, input logic [7:0] y);
		logic [16:0] name_at;
		logic [16:0] row_at;
		logic [16:0] pat_at;
		logic [16:0] col_at;
		logic [7:0]  tile;
		logic [7:0]  pattern;
		logic [7:0]  colors;
		name_at = (((name_base >> 10) & 17'h0000F) << 10) | (17'(y >> 3) << 5) | 17'(x >> 3);
		case (screen_mode)
			SCREEN_G1: begin
				tile   = vram_copy[name_at];
				pat_at = (((pattern_base >> 11) & 17'h00007) << 11) | (17'(tile) << 3)
					| 17'(y & 8'd7);
				col_at = (((color_base >> 6) & 17'h000FF) << 6) | 17'(tile >> 3);
			end
			SCREEN_G2, SCREEN_G3: begin
				tile   = vram_copy[name_at];
				row_at = (17'(tile) << 3) | 17'(y & 8'd7);
				// row bands pick the upper thirds of the pattern and colour tables
				if (y >= 8'd64 && y <= 8'd127)
					row_at = row_at | (pattern_base & 17'h00800);
				if (y >= 8'd128 && y <= 8'd191)
					row_at = row_at | (pattern_base & 17'h01000);
				pat_at = row_at | (pattern_base & 17'h02000);
				col_at = row_at | (color_base & 17'h02000);
			end
			SCREEN_G4: begin
				pat_at  = (name_base & 17'h18000) + (17'(y) << 7) + 17'(x >> 1);
				pattern = vram_copy[pat_at];
				return x[0] ? pattern[3:0] : pattern[7:4];
			end
			default: return 4'h0;
		endcase
		pattern = vram_copy[pat_at];
		colors  = vram_copy[col_at];
		return pattern[3'd7 - x[2:0]] ? colors[7:4] : colors[3:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [3:0] want;
		if (!arst_n) begin
			screen_mode  = '0;
			name_base    = '0;
			pattern_base = '0;
			color_base   = '0;
			expected_colors.delete();
		end else begin
			if (result_valid) begin
				if (expected_colors.size() == 0) begin
					report_mismatch($sformatf("color %0h with no pixel waiting", pixel_color));
				end else begin
					want = expected_colors.pop_front();
					if (pixel_color !== want)
						report_mismatch($sformatf("pixel_color %0h, want %0h", pixel_color, want));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SCREEN_MODE: screen_mode  = cfg_data[4:0];
					REG_NAME_BASE:   name_base    = cfg_data[16:0];
					REG_PAT_BASE:    pattern_base = cfg_data[16:0];
					REG_COLOR_BASE:  color_base   = cfg_data[16:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (mode == ITEM_WRITE)
					vram_copy[write_address] = write_data;
				else
					expected_colors.push_back(predict_color(pixel_x, pixel_y));
			end
		end
		colors_pending <= expected_colors.size();
	end

endmodule

@@ dv/tile_pattern_pixel_fetch_tb.sv @@
// tile_pattern_pixel_fetch_tb: drives write and pixel beats through several screen mode setups
// depends on tppf_pkg, the tile_pattern_pixel_fetch block and the tppf_checker module
module tile_pattern_pixel_fetch_tb
	import tppf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS_PER_PHASE = 36;
	localparam int DRAIN_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT  = 1000;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     start         = 1'b0;
	logic                     busy;
	logic                     mode          = ITEM_WRITE;
	logic [7:0]               pixel_x       = '0;
	logic [7:0]               pixel_y       = '0;
	logic [16:0]              write_address = '0;
	logic [7:0]               write_data    = '0;
	logic                     result_valid;
	logic [3:0]               pixel_color;
	logic                     cfg_we        = 1'b0;
	logic [REG_IDX_BITS-1:0]  cfg_index     = REG_SCREEN_MODE;
	logic [CFG_DATA_BITS-1:0] cfg_data      = '0;
	int                       fail_count;
	int                       colors_pending;

	// register values as last programmed, used only to steer stimulus
	logic [4:0]  cur_mode  = SCREEN_G1;
	logic [16:0] cur_name  = '0;
	logic [16:0] cur_pat   = '0;
	logic [16:0] cur_color = '0;

	// bytes written so far; a pixel never touches an entry missing here
	logic [7:0]  written_bytes [int];
	logic [16:0] last_fetch = '0;
	logic [7:0]  last_x     = '0;
	logic [7:0]  last_y     = '0;
	bit          steady     = 1'b0;     // back-to-back beats for the whole phase
	int          stall_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	tile_pattern_pixel_fetch i_dut (.*);

	tppf_checker i_checker (.*);

	// watchdog: nothing accepted on any channel for too long means a hang
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || cfg_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// one command beat: random gap first, then hold start until busy drops at an edge
	task automatic drive_beat(input logic kind, input logic [7:0] x, input logic [7:0] y,
			input logic [16:0] addr, input logic [7:0] data);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		mode          <= kind;
		pixel_x       <= x;
		pixel_y       <= y;
		write_address <= addr;
		write_data    <= data;
		do @(posedge clk); while (busy);
	endtask

	// pixel fields are don't-care on a write, so they carry noise
	task automatic write_byte(input logic [16:0] addr, input logic [7:0] data);
		written_bytes[addr] = data;
		drive_beat(ITEM_WRITE, 8'($urandom), 8'($urandom), addr, data);
	endtask

	task automatic fill_byte(input logic [16:0] addr);
		if (!written_bytes.exists(addr))
			write_byte(addr, 8'($urandom));
	endtask

	// make every byte this pixel will read valid, then send the pixel beat
	task automatic request_pixel(input logic [7:0] x, input logic [7:0] y);
		logic [16:0] name_at;
		logic [16:0] pat_at;
		logic [16:0] col_at;
		logic [1:0]  band;
		logic [7:0]  tile;
		case (cur_mode)
			SCREEN_G1, SCREEN_G2, SCREEN_G3: begin
				name_at = {3'b000, cur_name[13:10], y[7:3], x[7:3]};
				fill_byte(name_at);
				tile = written_bytes[name_at];
				if (cur_mode == SCREEN_G1) begin
					pat_at = {3'b000, cur_pat[13:11], tile, y[2:0]};
					col_at = {3'b000, cur_color[13:6], 1'b0, tile[7:3]};
				end else begin
					band   = {cur_pat[12] && y >= 8'd128 && y <= 8'd191,
						cur_pat[11] && y >= 8'd64 && y <= 8'd127};
					pat_at = {3'b000, cur_pat[13], band, tile, y[2:0]};
					col_at = {3'b000, cur_color[13], band, tile, y[2:0]};
				end
				fill_byte(pat_at);
				fill_byte(col_at);
				last_fetch = name_at;
			end
			SCREEN_G4: begin
				name_at = {cur_name[16:15], y, x[7:1]};
				fill_byte(name_at);
				last_fetch = name_at;
			end
			default: last_fetch = 17'($urandom);     // nothing is read, colour is 0
		endcase
		last_x = x;
		last_y = y;
		drive_beat(ITEM_PIXEL, x, y, 17'($urandom), 8'($urandom));
	endtask

	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// quiet the command channel and let the last pixel and any write fully retire
	task automatic settle();
		start <= 1'b0;
		while (colors_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [4:0] scr, input logic [16:0] ntb,
			input logic [16:0] ptb, input logic [16:0] ctb, input bit load_regs);
		int         n;
		int         pick;
		logic [7:0] ry;
		if (load_regs) begin
			settle();
			// upper bits of the mode write must be dropped by the block
			write_reg(REG_SCREEN_MODE, {12'($urandom), scr});
			write_reg(REG_NAME_BASE, ntb);
			write_reg(REG_PAT_BASE, ptb);
			write_reg(REG_COLOR_BASE, ctb);
			cfg_we <= 1'b0;
		end
		cur_mode  = scr;
		cur_name  = ntb;
		cur_pat   = ptb;
		cur_color = ctb;
		steady    = ($urandom_range(0, 3) == 0);

		// corners of the screen: first and last tile, both nibble parities
		request_pixel(8'h00, 8'h00);
		request_pixel(8'hFF, 8'hFF);

		for (n = 0; n < ITEMS_PER_PHASE; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				// stray write anywhere in memory
				write_byte(17'($urandom), 8'($urandom));
			end else if (pick < 3) begin
				// overwrite what the last pixel fetched first, then likely re-read it
				write_byte(last_fetch, 8'($urandom));
			end else if (pick < 5) begin
				request_pixel(last_x, last_y);
			end else begin
				// a quarter of the rows sit on the edges of the row bands
				if ($urandom_range(0, 3) == 0)
					ry = 8'($urandom_range(0, 3) * 64 + ($urandom_range(0, 1) ? 0 : 63));
				else
					ry = 8'($urandom);
				request_pixel(8'($urandom), ry);
			end
		end
	endtask

	initial begin
		logic [4:0] odd_mode;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of the write fields
		write_byte(17'h00000, 8'h00);
		write_byte(17'h1FFFF, 8'hFF);

		// reset values: graphic1 with every base at zero
		run_phase(SCREEN_G1, '0, '0, '0, 1'b0);
		run_phase(SCREEN_G1, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1'b1);
		run_phase(SCREEN_G2, 17'($urandom), 17'($urandom), 17'($urandom), 1'b1);
		// both row band bits on, then both off with the upper colour half
		run_phase(SCREEN_G3, 17'($urandom), 17'($urandom) | 17'h01800, 17'($urandom), 1'b1);
		run_phase(SCREEN_G2, 17'($urandom), 17'($urandom) & ~17'h01800,
			17'($urandom) | 17'h02000, 1'b1);
		// bitmap on the first and the last 32 KiB page
		run_phase(SCREEN_G4, '0, 17'($urandom), 17'($urandom), 1'b1);
		run_phase(SCREEN_G4, 17'h1FFFF, 17'($urandom), 17'($urandom), 1'b1);
		// modes without a renderer return colour 0
		do odd_mode = 5'($urandom); while (odd_mode[4] == 1'b0 && odd_mode[1:0] == 2'b00);
		run_phase(odd_mode, 17'($urandom), 17'($urandom), 17'($urandom), 1'b1);
		run_phase(5'h1F, 17'($urandom), 17'($urandom), 17'($urandom), 1'b1);
		run_phase(SCREEN_G1, 17'($urandom), 17'($urandom), 17'($urandom), 1'b1);

		settle();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
